[rtl/core/energy_covariance_propagation_defines.svh]
// Assertion macros shared by the energy covariance propagation RTL.
// Needs nothing else; included by the files that carry assertions.
`ifndef ENERGY_COVARIANCE_PROPAGATION_DEFINES_SVH
`define ENERGY_COVARIANCE_PROPAGATION_DEFINES_SVH

// Check that a property holds at every clock edge outside reset
`define ECP_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent
`define ECP_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`endif

[rtl/core/ecp_pkg.sv]
// Types and constants of the energy covariance propagation block.
// No dependencies; imported by the top module energy_covariance_propagation.
`timescale 1ns / 1ps

package ecp_pkg;

  localparam int MomFracBits = 20;
  localparam int CovOutBits  = 48;

  localparam logic [63:0] NanoPerUnit = 64'd1000000000;
  localparam logic [63:0] NanoHalf    = 64'd500000000;

  // Table masses, round half up at the momentum scale
  localparam logic [30:0] MassElectron = 31'(((64'd510999    << MomFracBits) + NanoHalf) / NanoPerUnit);
  localparam logic [30:0] MassMuon     = 31'(((64'd105658400 << MomFracBits) + NanoHalf) / NanoPerUnit);
  localparam logic [30:0] MassKaon     = 31'(((64'd493677000 << MomFracBits) + NanoHalf) / NanoPerUnit);
  localparam logic [30:0] MassProton   = 31'(((64'd938272000 << MomFracBits) + NanoHalf) / NanoPerUnit);
  localparam logic [30:0] MassPion     = 31'(((64'd139570000 << MomFracBits) + NanoHalf) / NanoPerUnit);

  localparam logic signed [31:0] CodeElectron = 32'sd11;
  localparam logic signed [31:0] CodeMuon     = 32'sd13;
  localparam logic signed [31:0] CodeKaon     = 32'sd321;
  localparam logic signed [31:0] CodeProton   = 32'sd2212;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic        [30:0] mass;
    logic signed [31:0] pdg_code;
    logic signed [47:0] cov_xx;
    logic signed [47:0] cov_xy;
    logic signed [47:0] cov_xz;
    logic signed [47:0] cov_yy;
    logic signed [47:0] cov_yz;
    logic signed [47:0] cov_zz;
  } in_item_t;

  typedef struct packed {
    logic        [31:0] energy;
    logic signed [47:0] cov_px_e;
    logic signed [47:0] cov_py_e;
    logic signed [47:0] cov_pz_e;
    logic signed [47:0] var_e;
    logic               overflow;
    logic               energy_zero;
  } out_item_t;

endpackage

[rtl/core/ecp_sqrt.sv]
// Pipelined integer square root, one result bit per stage, 64-bit radicand.
// No dependencies; carries a side payload in step with the root.
`timescale 1ns / 1ps

module ecp_sqrt #(
  parameter int PW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [63:0]   s_i,
  input  logic [PW-1:0] pay_i,
  output logic          valid_o,
  output logic [31:0]   root_o,
  output logic [PW-1:0] pay_o
);

  localparam int RW = 32;
  localparam int SW = 2 * RW;

  logic [SW-1:0] rem_s [RW+1];
  logic [SW-1:0] res_s [RW+1];
  logic          vld_s [RW+1];
  logic [PW-1:0] pay_s [RW+1];

  assign rem_s[0] = s_i;
  assign res_s[0] = '0;
  assign vld_s[0] = valid_i;
  assign pay_s[0] = pay_i;

  for (genvar k = 0; k < RW; k++) begin : g_stage
    localparam logic [SW-1:0] BitK = SW'(1) << (2 * (RW - 1 - k));
    logic [SW-1:0] trial;
    logic          take;
    logic [SW-1:0] rem_q, res_q;
    logic          vld_q;
    logic [PW-1:0] pay_q;

    // Try the next root bit against the remaining radicand
    assign trial = res_s[k] + BitK;
    assign take  = (rem_s[k] >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en_i) begin
        vld_q <= vld_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q <= take ? (rem_s[k] - trial) : rem_s[k];
        res_q <= take ? ((res_s[k] >> 1) + BitK) : (res_s[k] >> 1);
        pay_q <= pay_s[k];
      end
    end

    assign rem_s[k+1] = rem_q;
    assign res_s[k+1] = res_q;
    assign vld_s[k+1] = vld_q;
    assign pay_s[k+1] = pay_q;
  end

  assign valid_o = vld_s[RW];
  assign root_o  = res_s[RW][RW-1:0];
  assign pay_o   = pay_s[RW];

endmodule

[rtl/core/ecp_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
// No dependencies; starts from a partial remainder below the divisor.
`timescale 1ns / 1ps

module ecp_div #(
  parameter int DW = 32,
  parameter int QW = 48,
  parameter int PW = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [DW-1:0] r0_i,
  input  logic [QW-1:0] n_i,
  input  logic [DW-1:0] d_i,
  input  logic [PW-1:0] pay_i,
  output logic          valid_o,
  output logic [QW-1:0] q_o,
  output logic [PW-1:0] pay_o
);

  logic [DW-1:0] r_s   [QW+1];
  logic [QW-1:0] n_s   [QW+1];
  logic [QW-1:0] q_s   [QW+1];
  logic [DW-1:0] d_s   [QW+1];
  logic          vld_s [QW+1];
  logic [PW-1:0] pay_s [QW+1];

  assign r_s[0]   = r0_i;
  assign n_s[0]   = n_i;
  assign q_s[0]   = '0;
  assign d_s[0]   = d_i;
  assign vld_s[0] = valid_i;
  assign pay_s[0] = pay_i;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;
    logic [DW-1:0] r_q, d_q;
    logic [QW-1:0] n_q, q_q;
    logic          vld_q;
    logic [PW-1:0] pay_q;

    // Shift in the next numerator bit and subtract where it fits
    assign trial = {r_s[k], n_s[k][QW-1]};
    assign diff  = trial - {1'b0, d_s[k]};
    assign ge    = (trial >= {1'b0, d_s[k]});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en_i) begin
        vld_q <= vld_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q   <= ge ? diff[DW-1:0] : trial[DW-1:0];
        n_q   <= n_s[k] << 1;
        q_q   <= {q_s[k][QW-2:0], ge};
        d_q   <= d_s[k];
        pay_q <= pay_s[k];
      end
    end

    assign r_s[k+1]   = r_q;
    assign n_s[k+1]   = n_q;
    assign q_s[k+1]   = q_q;
    assign d_s[k+1]   = d_q;
    assign vld_s[k+1] = vld_q;
    assign pay_s[k+1] = pay_q;
  end

  assign valid_o = vld_s[QW];
  assign q_o     = q_s[QW];
  assign pay_o   = pay_s[QW];

endmodule

[rtl/core/energy_covariance_propagation.sv]
// Items pass the front stages, 32-stage root, X1, X2, 48-stage dividers and output register.
// One item per cycle while the output is not stalled; root and dividers are fully pipelined.
// A stalled output holds the whole pipeline in place; nothing is lost or repeated.
// Reset clears the stage valid bits only; datapath registers are not reset.
`timescale 1ns / 1ps
`include "energy_covariance_propagation_defines.svh"

module energy_covariance_propagation import ecp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  typedef struct packed {
    logic [63:0]      s;
    logic [2:0][81:0] n;
    logic [115:0]     v;
  } sq_pay_t;

  typedef struct packed {
    logic [31:0] e;
    logic        zero;
    logic        neg;
    logic        pre;
  } vpay_t;

  function automatic int cidx(input int i, input int j);
    int lo, hi;
    lo = (i < j) ? i : j;
    hi = (i < j) ? j : i;
    if (lo == 0) return hi;
    if (lo == 1) return hi + 2;
    return 5;
  endfunction

  // Clamp a quotient magnitude and restore its sign; bit 48 flags saturation
  function automatic logic [CovOutBits:0] sat(input logic [CovOutBits-1:0] q,
                                              input logic neg, input logic pre);
    logic [CovOutBits-1:0] lim, v;
    logic                  ovf;
    lim = neg ? (CovOutBits'(1) << (CovOutBits - 1))
              : ((CovOutBits'(1) << (CovOutBits - 1)) - CovOutBits'(1));
    ovf = pre | (q > lim);
    v   = ovf ? lim : q;
    return {ovf, neg ? (CovOutBits'(0) - v) : v};
  endfunction

  logic adv;

  // Advance the whole pipeline unless a finished item is held at the output
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  // ---------------- stage 1: register item, pick the mass ----------------
  logic [30:0]        mass_d;
  logic [6:0]         vld_q;
  logic signed [31:0] r1_p_q [3];
  logic [30:0]        r1_m_q;
  logic signed [47:0] r1_c_q [6];

  always_comb begin
    if (!in_item_i.kind) begin
      mass_d = in_item_i.mass;
    end else if (in_item_i.pdg_code == CodeElectron || in_item_i.pdg_code == -CodeElectron) begin
      mass_d = MassElectron;
    end else if (in_item_i.pdg_code == CodeMuon || in_item_i.pdg_code == -CodeMuon) begin
      mass_d = MassMuon;
    end else if (in_item_i.pdg_code == CodeKaon || in_item_i.pdg_code == -CodeKaon) begin
      mass_d = MassKaon;
    end else if (in_item_i.pdg_code == CodeProton || in_item_i.pdg_code == -CodeProton) begin
      mass_d = MassProton;
    end else begin
      mass_d = MassPion;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[5:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      r1_p_q[0] <= in_item_i.px;
      r1_p_q[1] <= in_item_i.py;
      r1_p_q[2] <= in_item_i.pz;
      r1_m_q    <= mass_d;
      r1_c_q[0] <= in_item_i.cov_xx;
      r1_c_q[1] <= in_item_i.cov_xy;
      r1_c_q[2] <= in_item_i.cov_xz;
      r1_c_q[3] <= in_item_i.cov_yy;
      r1_c_q[4] <= in_item_i.cov_yz;
      r1_c_q[5] <= in_item_i.cov_zz;
    end
  end

  // ---------------- stage 2: squares and covariance partial products ----------------
  logic signed [63:0] sq_d [3];
  logic [63:0]        msq_d;
  logic [63:0]        r2_sq_q [4];
  logic signed [55:0] phi_d [9];
  logic signed [56:0] plo_d [9];
  logic signed [55:0] phi_q [9];
  logic signed [56:0] plo_q [9];
  logic signed [31:0] r2_p_q [3];

  for (genvar i = 0; i < 3; i++) begin : g_sq
    assign sq_d[i] = r1_p_q[i] * r1_p_q[i];
    for (genvar j = 0; j < 3; j++) begin : g_pp
      assign phi_d[i*3+j] = $signed(r1_c_q[cidx(i, j)][47:24]) * r1_p_q[j];
      assign plo_d[i*3+j] = $signed({1'b0, r1_c_q[cidx(i, j)][23:0]}) * r1_p_q[j];
    end
  end
  assign msq_d = 64'(r1_m_q) * 64'(r1_m_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        r2_sq_q[i] <= $unsigned(sq_d[i]);
        r2_p_q[i]  <= r1_p_q[i];
      end
      r2_sq_q[3] <= msq_d;
      for (int k = 0; k < 9; k++) begin
        phi_q[k] <= phi_d[k];
        plo_q[k] <= plo_d[k];
      end
    end
  end

  // ---------------- stage 3: sum of squares, full covariance terms ----------------
  logic [63:0]        r3_s_q;
  logic signed [80:0] term_q [9];
  logic signed [31:0] r3_p_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      r3_s_q <= r2_sq_q[0] + r2_sq_q[1] + r2_sq_q[2] + r2_sq_q[3];
      for (int k = 0; k < 9; k++) begin
        term_q[k] <= (81'(phi_q[k]) <<< 24) + 81'(plo_q[k]);
      end
      for (int i = 0; i < 3; i++) begin
        r3_p_q[i] <= r2_p_q[i];
      end
    end
  end

  // ---------------- stage 4: row sums N_i = sum_j C_ij p_j ----------------
  logic [63:0]        r4_s_q;
  logic signed [81:0] r4_n_q [3];
  logic signed [31:0] r4_p_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      r4_s_q <= r3_s_q;
      for (int i = 0; i < 3; i++) begin
        r4_n_q[i] <= 82'(term_q[3*i]) + 82'(term_q[3*i+1]) + 82'(term_q[3*i+2]);
        r4_p_q[i] <= r3_p_q[i];
      end
    end
  end

  // ---------------- stage 5: p_i * N_i in three slices ----------------
  logic [83:0]        nx_d [3];
  logic signed [60:0] pq_d [9];
  logic signed [60:0] pq_q [9];
  logic [63:0]        r5_s_q;
  logic signed [81:0] r5_n_q [3];

  for (genvar i = 0; i < 3; i++) begin : g_pq
    assign nx_d[i]     = 84'(r4_n_q[i]);
    assign pq_d[3*i]   = r4_p_q[i] * $signed({1'b0, nx_d[i][27:0]});
    assign pq_d[3*i+1] = r4_p_q[i] * $signed({1'b0, nx_d[i][55:28]});
    assign pq_d[3*i+2] = r4_p_q[i] * $signed(nx_d[i][83:56]);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      r5_s_q <= r4_s_q;
      for (int k = 0; k < 9; k++) begin
        pq_q[k] <= pq_d[k];
      end
      for (int i = 0; i < 3; i++) begin
        r5_n_q[i] <= r4_n_q[i];
      end
    end
  end

  // ---------------- stage 6: recombine slices ----------------
  logic signed [115:0] t_q [3];
  logic [63:0]         r6_s_q;
  logic signed [81:0]  r6_n_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      r6_s_q <= r5_s_q;
      for (int i = 0; i < 3; i++) begin
        t_q[i]    <= (116'(pq_q[3*i+2]) <<< 56) + (116'(pq_q[3*i+1]) <<< 28)
                     + 116'(pq_q[3*i]);
        r6_n_q[i] <= r5_n_q[i];
      end
    end
  end

  // ---------------- stage 7: var numerator p^T C p ----------------
  logic signed [115:0] r7_v_q;
  logic [63:0]         r7_s_q;
  logic signed [81:0]  r7_n_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      r7_v_q <= t_q[0] + t_q[1] + t_q[2];
      r7_s_q <= r6_s_q;
      for (int i = 0; i < 3; i++) begin
        r7_n_q[i] <= r6_n_q[i];
      end
    end
  end

  // ---------------- square root ----------------
  sq_pay_t     sq_in, sq_out;
  logic        sq_vld;
  logic [31:0] root;

  assign sq_in.s    = r7_s_q;
  assign sq_in.n[0] = r7_n_q[0];
  assign sq_in.n[1] = r7_n_q[1];
  assign sq_in.n[2] = r7_n_q[2];
  assign sq_in.v    = r7_v_q;

  ecp_sqrt #(
    .PW ($bits(sq_pay_t))
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (vld_q[6]),
    .s_i     (r7_s_q),
    .pay_i   (sq_in),
    .valid_o (sq_vld),
    .root_o  (root),
    .pay_o   (sq_out)
  );

  // ---------------- X1: signs and magnitudes ----------------
  logic               x1_vld_q, x2_vld_q;
  logic [31:0]        x1_e_q;
  logic [63:0]        x1_s_q;
  logic               x1_zero_q;
  logic [2:0]         x1_negn_q;
  logic [79:0]        x1_magn_q [3];
  logic               x1_negv_q;
  logic [112:0]       x1_magv_q;
  logic [81:0]        negn_d [3];
  logic [115:0]       negv_d;

  for (genvar i = 0; i < 3; i++) begin : g_mag
    assign negn_d[i] = 82'(0) - sq_out.n[i];
  end
  assign negv_d = 116'(0) - sq_out.v;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x1_vld_q <= 1'b0;
      x2_vld_q <= 1'b0;
    end else if (adv) begin
      x1_vld_q <= sq_vld;
      x2_vld_q <= x1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x1_e_q    <= root;
      x1_s_q    <= sq_out.s;
      x1_zero_q <= (root == '0);
      for (int i = 0; i < 3; i++) begin
        x1_negn_q[i] <= sq_out.n[i][81];
        x1_magn_q[i] <= sq_out.n[i][81] ? negn_d[i][79:0] : sq_out.n[i][79:0];
      end
      x1_negv_q <= sq_out.v[115];
      x1_magv_q <= sq_out.v[115] ? negv_d[112:0] : sq_out.v[112:0];
    end
  end

  // ---------------- X2: range precheck and divider set-up ----------------
  logic [31:0] x2_e_q;
  logic [63:0] x2_s_q;
  logic        x2_zero_q;
  logic [2:0]  x2_negn_q, x2_pren_q;
  logic [31:0] x2_r0n_q [3];
  logic [47:0] x2_lon_q [3];
  logic        x2_negv_q, x2_prev_q;
  logic [63:0] x2_r0v_q;
  logic [47:0] x2_lov_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x2_e_q    <= x1_e_q;
      x2_s_q    <= x1_s_q;
      x2_zero_q <= x1_zero_q;
      x2_negn_q <= x1_negn_q;
      for (int i = 0; i < 3; i++) begin
        x2_pren_q[i] <= (x1_magn_q[i][79:48] >= x1_e_q);
        x2_r0n_q[i]  <= x1_magn_q[i][79:48];
        x2_lon_q[i]  <= x1_magn_q[i][47:0];
      end
      x2_negv_q <= x1_negv_q;
      x2_prev_q <= (x1_magv_q[112:48] >= {1'b0, x1_s_q});
      x2_r0v_q  <= x1_magv_q[111:48];
      x2_lov_q  <= x1_magv_q[47:0];
    end
  end

  // ---------------- dividers ----------------
  logic [2:0]  cdv_vld;
  logic [47:0] cdv_q [3];
  logic [1:0]  cdv_pay [3];
  logic        vdv_vld;
  logic [47:0] vdv_q;
  vpay_t       vdv_in, vdv_out;

  for (genvar i = 0; i < 3; i++) begin : g_cdiv
    ecp_div #(
      .DW (32),
      .QW (CovOutBits),
      .PW (2)
    ) u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (x2_vld_q),
      .r0_i    (x2_r0n_q[i]),
      .n_i     (x2_lon_q[i]),
      .d_i     (x2_e_q),
      .pay_i   ({x2_negn_q[i], x2_pren_q[i]}),
      .valid_o (cdv_vld[i]),
      .q_o     (cdv_q[i]),
      .pay_o   (cdv_pay[i])
    );
  end

  assign vdv_in.e    = x2_e_q;
  assign vdv_in.zero = x2_zero_q;
  assign vdv_in.neg  = x2_negv_q;
  assign vdv_in.pre  = x2_prev_q;

  ecp_div #(
    .DW (64),
    .QW (CovOutBits),
    .PW ($bits(vpay_t))
  ) u_vdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (x2_vld_q),
    .r0_i    (x2_r0v_q),
    .n_i     (x2_lov_q),
    .d_i     (x2_s_q),
    .pay_i   (vdv_in),
    .valid_o (vdv_vld),
    .q_o     (vdv_q),
    .pay_o   (vdv_out)
  );

  // ---------------- output: saturate, zero case, register ----------------
  logic [CovOutBits:0] sat_c [3];
  logic [CovOutBits:0] sat_v;
  logic                out_valid_q;
  out_item_t           out_item_q;

  for (genvar i = 0; i < 3; i++) begin : g_sat
    assign sat_c[i] = sat(cdv_q[i], cdv_pay[i][1], cdv_pay[i][0]);
  end
  assign sat_v = sat(vdv_q, vdv_out.neg, vdv_out.pre);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= vdv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_item_q.energy <= vdv_out.e;
      if (vdv_out.zero) begin
        out_item_q.cov_px_e    <= '0;
        out_item_q.cov_py_e    <= '0;
        out_item_q.cov_pz_e    <= '0;
        out_item_q.var_e       <= '0;
        out_item_q.overflow    <= 1'b0;
        out_item_q.energy_zero <= 1'b1;
      end else begin
        out_item_q.cov_px_e    <= sat_c[0][CovOutBits-1:0];
        out_item_q.cov_py_e    <= sat_c[1][CovOutBits-1:0];
        out_item_q.cov_pz_e    <= sat_c[2][CovOutBits-1:0];
        out_item_q.var_e       <= sat_v[CovOutBits-1:0];
        out_item_q.overflow    <= sat_c[0][CovOutBits] | sat_c[1][CovOutBits]
                                  | sat_c[2][CovOutBits] | sat_v[CovOutBits];
        out_item_q.energy_zero <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // ---------------- assertions ----------------
  `ECP_ASSERT_IMPLY(a_stall_only_when_held, clk_i, rst_ni, in_stall_o, out_valid_o, "input stalled without a held result")
  `ECP_ASSERT(a_dividers_lockstep, clk_i, rst_ni, (cdv_vld[0] == vdv_vld) && (cdv_vld[1] == vdv_vld) && (cdv_vld[2] == vdv_vld), "divider valid bits disagree")
  `ECP_ASSERT_IMPLY(a_zero_energy_clean, clk_i, rst_ni, out_valid_o && out_item_o.energy_zero, (out_item_o.var_e == '0) && (out_item_o.cov_px_e == '0) && !out_item_o.overflow, "zero energy item carries nonzero results")
  `ECP_ASSERT_IMPLY(a_energy_nonzero, clk_i, rst_ni, out_valid_o && !out_item_o.energy_zero, out_item_o.energy != '0, "zero energy without flag")

endmodule
